@@ rtl/cdrs_pkg.sv @@
package cdrs_pkg;

    // Command opcodes as seen on the input channel
    localparam logic [2:0] OP_RESTART = 3'd0;
    localparam logic [2:0] OP_HEADER  = 3'd1;
    localparam logic [2:0] OP_BYTE    = 3'd2;
    localparam logic [2:0] OP_HALF    = 3'd3;
    localparam logic [2:0] OP_WORD    = 3'd4;
    localparam logic [2:0] OP_DOUBLE  = 3'd5;

    localparam int          DEF_OFFSET_BITS = 16;
    localparam logic [15:0] CAP_RESET       = 16'd1024;
    localparam int          QUEUE_DEPTH     = 2;

    // Encapsulation header 00 01 00 00, sent least significant byte first
    localparam logic [63:0] HDR_VALUE = 64'h0000_0000_0000_0100;

    typedef enum logic [1:0] {
        CMD_RESTART,
        CMD_FAIL,
        CMD_WRITE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [3:0]  nbytes;
        logic        align;
        logic [63:0] value;
    } cmd_t;

endpackage

@@ rtl/cdrs_front.sv @@
module cdrs_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [2:0]    s_opcode,
    input  logic [63:0]   s_value,
    input  logic          q_full,
    output logic          push,
    output cdrs_pkg::cmd_t push_cmd
);
    import cdrs_pkg::*;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Classify the opcode into a plain write of n bytes or a status command
    always_comb begin
        push_cmd.kind   = CMD_WRITE;
        push_cmd.nbytes = 4'd1;
        push_cmd.align  = 1'b1;
        push_cmd.value  = s_value;
        case (s_opcode)
            OP_RESTART: begin
                push_cmd.kind = CMD_RESTART;
            end
            OP_HEADER: begin
                push_cmd.nbytes = 4'd4;
                push_cmd.align  = 1'b0;
                push_cmd.value  = HDR_VALUE;
            end
            OP_BYTE: begin
                push_cmd.nbytes = 4'd1;
            end
            OP_HALF: begin
                push_cmd.nbytes = 4'd2;
            end
            OP_WORD: begin
                push_cmd.nbytes = 4'd4;
            end
            OP_DOUBLE: begin
                push_cmd.nbytes = 4'd8;
            end
            default: begin
                push_cmd.kind = CMD_FAIL;
            end
        endcase
    end
endmodule

@@ rtl/cdrs_queue.sv @@
module cdrs_queue #(
    parameter int DEPTH = cdrs_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cdrs_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output cdrs_pkg::cmd_t pop_cmd
);
    import cdrs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

@@ rtl/cdrs_back.sv @@
module cdrs_back #(
    parameter int OFFSET_BITS = cdrs_pkg::DEF_OFFSET_BITS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [15:0]    cfg_wdata,
    input  logic           q_valid,
    input  cdrs_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_byte,
    output logic [15:0]    m_offset,
    output logic           m_byte_valid,
    output logic           m_ok,
    output logic           m_last
);
    import cdrs_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int CW = (OB > 16) ? OB : 16;
    localparam logic [CW-1:0] POS_MASK = CW'((64'd1 << OB) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_CHECK,
        S_DATA
    } state_t;

    state_t         state_reg, state_next;
    logic [OB-1:0]  pos_reg, pos_next;
    logic [2:0]     pad_reg, pad_next;
    logic [3:0]     left_reg, left_next;
    logic [63:0]    val_reg, val_next;
    logic [15:0]    cap_reg, cap_next;
    logic           mv_reg, mv_next;
    logic [7:0]     mb_reg, mb_next;
    logic [15:0]    mo_reg, mo_next;
    logic           mbv_reg, mbv_next;
    logic           mok_reg, mok_next;
    logic           ml_reg, ml_next;

    logic [CW-1:0]  cap_ext, eff_ext;
    logic [OB-1:0]  eff_cap, room_left;
    logic           out_free, room_ok, emit_byte;
    logic [2:0]     size_mask, rem;

    assign cap_ext   = CW'(cap_reg);
    assign eff_ext   = (cap_ext > POS_MASK) ? POS_MASK : cap_ext;
    assign eff_cap   = OB'(eff_ext);
    assign room_left = eff_cap - pos_reg;
    assign room_ok   = (pos_reg <= eff_cap) && (OB'(left_reg) <= room_left);
    assign out_free  = !mv_reg || m_ready;

    assign size_mask = 3'(q_cmd.nbytes - 4'd1);
    assign rem       = pos_reg[2:0] & size_mask;

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        pad_next   = pad_reg;
        left_next  = left_reg;
        val_next   = val_reg;
        cap_next   = cfg_we ? cfg_wdata : cap_reg;
        mv_next    = (mv_reg && m_ready) ? 1'b0 : mv_reg;
        mb_next    = mb_reg;
        mo_next    = mo_reg;
        mbv_next   = mbv_reg;
        mok_next   = mok_reg;
        ml_next    = ml_reg;
        q_pop      = 1'b0;
        emit_byte  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_RESTART: begin
                            pos_next = '0;
                            mv_next  = 1'b1;
                            mb_next  = 8'h00;
                            mo_next  = 16'h0000;
                            mbv_next = 1'b0;
                            mok_next = 1'b1;
                            ml_next  = 1'b1;
                        end
                        CMD_WRITE: begin
                            val_next   = q_cmd.value;
                            left_next  = q_cmd.nbytes;
                            pad_next   = q_cmd.align
                                       ? 3'(q_cmd.nbytes - {1'b0, rem}) & size_mask : 3'd0;
                            state_next = S_PAD;
                        end
                        default: begin
                            mv_next  = 1'b1;
                            mb_next  = 8'h00;
                            mo_next  = 16'(pos_reg);
                            mbv_next = 1'b0;
                            mok_next = 1'b0;
                            ml_next  = 1'b1;
                        end
                    endcase
                end
            end
            S_PAD: begin
                // stop padding once aligned or the buffer is full
                if (pad_reg == 3'd0 || pos_reg >= eff_cap) begin
                    state_next = S_CHECK;
                end else if (out_free) begin
                    emit_byte = 1'b1;
                    mv_next   = 1'b1;
                    mb_next   = 8'h00;
                    mo_next   = 16'(pos_reg);
                    mbv_next  = 1'b1;
                    mok_next  = 1'b0;
                    ml_next   = 1'b0;
                    pos_next  = pos_reg + 1'b1;
                    pad_next  = pad_reg - 3'd1;
                end
            end
            S_CHECK: begin
                if (room_ok) begin
                    state_next = S_DATA;
                end else if (out_free) begin
                    mv_next    = 1'b1;
                    mb_next    = 8'h00;
                    mo_next    = 16'(pos_reg);
                    mbv_next   = 1'b0;
                    mok_next   = 1'b0;
                    ml_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DATA: begin
                if (out_free) begin
                    emit_byte = 1'b1;
                    mv_next   = 1'b1;
                    mb_next   = val_reg[7:0];
                    mo_next   = 16'(pos_reg);
                    mbv_next  = 1'b1;
                    mok_next  = (left_reg == 4'd1);
                    ml_next   = (left_reg == 4'd1);
                    pos_next  = pos_reg + 1'b1;
                    val_next  = val_reg >> 8;
                    left_next = left_reg - 4'd1;
                    if (left_reg == 4'd1) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            cap_reg   <= CAP_RESET;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cap_reg   <= cap_next;
            mv_reg    <= mv_next;
        end
        pad_reg  <= pad_next;
        left_reg <= left_next;
        val_reg  <= val_next;
        mb_reg   <= mb_next;
        mo_reg   <= mo_next;
        mbv_reg  <= mbv_next;
        mok_reg  <= mok_next;
        ml_reg   <= ml_next;
    end

    assign m_valid      = mv_reg;
    assign m_byte       = mb_reg;
    assign m_offset     = mo_reg;
    assign m_byte_valid = mbv_reg;
    assign m_ok         = mok_reg;
    assign m_last       = ml_reg;

    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DATA |-> left_reg != 4'd0)
        else $error("data phase entered with no bytes left");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !mbv_reg |-> ml_reg)
        else $error("status-only result not marked last");

    a_ok_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !ml_reg |-> !mok_reg)
        else $error("ok raised on a result that is not last");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_byte |=> pos_reg == OB'($past(pos_reg) + 1'b1))
        else $error("write position did not advance by one byte");
endmodule

@@ rtl/cdr_le_serializer_unit.sv @@
// Little-endian CDR serializer.
// Input channel (s_): one request per command. s_tuser carries the
// opcode (restart, header, byte, half word, word, double word), s_tdata
// the raw value; only the low bytes of the command's size are used.
// Output channel (m_): one request per buffer byte or status result.
// m_tdata holds the byte and its buffer offset, m_tuser the byte-valid and
// ok flags, m_tlast closes each command's result run.
// Capacity is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, the block itself does not enforce this.
// A front stage decodes commands into a two-entry queue; the back sequencer
// owns the write position and emits at most one result per cycle into an
// output register. A command is dispatched from the queue, then its pad
// bytes go out in the pad phase, the room is checked and its value bytes
// go out one by one; a status-only command is answered at dispatch. An
// accepted command is first stored in the queue, and each of its results
// is then registered in the output register.
// Reset clears the position to zero and capacity to 1024 bytes. When the
// receiver stalls, the output register holds and the sequencer waits;
// input keeps being taken until the queue fills.
module cdr_le_serializer_unit #(
    parameter int OFFSET_BITS = cdrs_pkg::DEF_OFFSET_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,  // capacity
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] value
    input  logic [2:0]  s_tuser,    // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] data_byte, [23:8] byte_offset
    output logic [1:0]  m_tuser,    // [0] byte_valid, [1] ok
    output logic        m_tlast
);
    import cdrs_pkg::*;

    cmd_t        push_cmd, pop_cmd;
    logic        push, q_full, q_pop, q_valid;
    logic [7:0]  m_byte;
    logic [15:0] m_offset;
    logic        m_byte_valid, m_ok;

    // Decode commands and hand them to the queue
    cdrs_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_opcode (s_tuser),
        .s_value  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Decouple decoding from byte emission
    cdrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cmd   (pop_cmd)
    );

    // Pad, check room and emit bytes against the write position
    cdrs_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_byte       (m_byte),
        .m_offset     (m_offset),
        .m_byte_valid (m_byte_valid),
        .m_ok         (m_ok),
        .m_last       (m_tlast)
    );

    assign m_tdata = {m_offset, m_byte};
    assign m_tuser = {m_ok, m_byte_valid};
endmodule

@@ tb/cdr_le_serializer_unit_test.sv @@
module cdr_le_serializer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdrs_pkg::*;

    // Opcodes the block does not define; both must close with a failure status
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Settle time after the last result, covering a double word with full pad
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] value;
    } cdr_cmd_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] byte_offset;
        logic        byte_valid;
        logic        ok;
        logic        last;
    } cdr_result_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = 64'd0;
    logic [2:0]  s_tuser   = OP_RESTART;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Stimulus side: requests waiting to go out, and counts for the drain check
    cdr_cmd_t    cmd_pending[$];
    int unsigned cmds_queued   = 0;
    int unsigned cmds_accepted = 0;
    bit          req_accepted  = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Predicted byte stream and the mirrored serializer state
    cdr_result_t byte_stream_q[$];
    logic [15:0] model_pos;
    logic [15:0] model_cap;

    int unsigned results_seen = 0;
    int unsigned bytes_seen   = 0;
    int unsigned fail_status  = 0;
    int unsigned cap_settings = 0;
    int unsigned error_count  = 0;

    cdr_le_serializer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // Serializer prediction
    // ---------------------------------------------------------------

    // Append one buffer byte at the current position and advance it
    function void stream_byte(logic [7:0] b, bit fin);
        cdr_result_t r;
        r.data_byte   = b;
        r.byte_offset = model_pos;
        r.byte_valid  = 1'b1;
        r.ok          = fin;
        r.last        = fin;
        byte_stream_q.push_back(r);
        model_pos = model_pos + 16'd1;
    endfunction

    // Close the command with a status-only result carrying the position
    function void stream_status(bit okv);
        cdr_result_t r;
        r.data_byte   = 8'h00;
        r.byte_offset = model_pos;
        r.byte_valid  = 1'b0;
        r.ok          = okv;
        r.last        = 1'b1;
        byte_stream_q.push_back(r);
    endfunction

    // A position past capacity leaves no room at all
    function bit buffer_fits(int unsigned n);
        if (model_pos > model_cap) begin
            return 1'b0;
        end
        return n <= (model_cap - model_pos);
    endfunction

    // Align to the value size with zero pad, stop padding at capacity,
    // then send the value least significant byte first or fail
    function void stream_aligned(logic [63:0] v, int unsigned n);
        int unsigned rem;
        int unsigned k;
        rem = model_pos & (n - 1);
        if (rem != 0) begin
            for (k = 0; k < n - rem && model_pos < model_cap; k++) begin
                stream_byte(8'h00, 1'b0);
            end
        end
        if (!buffer_fits(n)) begin
            stream_status(1'b0);
            return;
        end
        for (k = 0; k < n; k++) begin
            stream_byte(v[8*k +: 8], k == n - 1);
        end
    endfunction

    function void serialize_cmd(logic [2:0] op, logic [63:0] v);
        int unsigned k;
        case (op)
            OP_RESTART: begin
                model_pos = 16'd0;
                stream_status(1'b1);
            end
            OP_HEADER: begin
                // Header ignores alignment and goes out whole or not at all
                if (!buffer_fits(4)) begin
                    stream_status(1'b0);
                end else begin
                    for (k = 0; k < 4; k++) begin
                        stream_byte(HDR_VALUE[8*k +: 8], k == 3);
                    end
                end
            end
            OP_BYTE: begin
                if (!buffer_fits(1)) begin
                    stream_status(1'b0);
                end else begin
                    stream_byte(v[7:0], 1'b1);
                end
            end
            OP_HALF:   stream_aligned(v, 2);
            OP_WORD:   stream_aligned(v, 4);
            OP_DOUBLE: stream_aligned(v, 8);
            default:   stream_status(1'b0);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ---------------------------------------------------------------

    always @(negedge aclk) begin
        cdr_cmd_t nxt;
        // Hold a request until the block takes it, then pick the next or idle
        if (!s_tvalid || req_accepted) begin
            if (cmd_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = cmd_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.opcode;
                s_tdata  <= nxt.value;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        // Stall the result channel at random
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        cdr_result_t got;
        cdr_result_t want;
        req_accepted <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            serialize_cmd(s_tuser, s_tdata);
            cmds_accepted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.data_byte   = m_tdata[7:0];
            got.byte_offset = m_tdata[23:8];
            got.byte_valid  = m_tuser[0];
            got.ok          = m_tuser[1];
            got.last        = m_tlast;
            results_seen++;
            if (got.byte_valid) bytes_seen++;
            if (got.last && !got.ok) fail_status++;
            if (byte_stream_q.size() == 0) begin
                $display("%0t: unexpected result byte=%02h off=%0d valid=%b ok=%b last=%b",
                         $time, got.data_byte, got.byte_offset, got.byte_valid,
                         got.ok, got.last);
                error_count++;
            end else begin
                want = byte_stream_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected byte=%02h off=%0d valid=%b ok=%b last=%b",
                             $time, want.data_byte, want.byte_offset, want.byte_valid,
                             want.ok, want.last);
                    $display("%0t:          actual   byte=%02h off=%0d valid=%b ok=%b last=%b",
                             $time, got.data_byte, got.byte_offset, got.byte_valid,
                             got.ok, got.last);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_cmd(logic [2:0] op, logic [63:0] v);
        cdr_cmd_t c;
        c.opcode = op;
        c.value  = v;
        cmd_pending.push_back(c);
        cmds_queued++;
    endtask

    // Mostly value writes with random content; restarts keep the position
    // cycling through small buffers, a few spare opcodes add noise
    task automatic queue_random_cmd();
        int unsigned pick;
        int unsigned vsel;
        logic [2:0]  op;
        logic [63:0] v;
        pick = $urandom_range(99);
        if (pick < 9)       op = OP_RESTART;
        else if (pick < 17) op = OP_HEADER;
        else if (pick < 36) op = OP_BYTE;
        else if (pick < 55) op = OP_HALF;
        else if (pick < 74) op = OP_WORD;
        else if (pick < 95) op = OP_DOUBLE;
        else if (pick < 98) op = OP_SPARE_LO;
        else                op = OP_SPARE_HI;
        vsel = $urandom_range(9);
        if (vsel == 0)      v = 64'd0;
        else if (vsel == 1) v = {64{1'b1}};
        else                v = {$urandom, $urandom};
        queue_cmd(op, v);
    endtask

    // Wait until every request is taken and every result has come, then settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (cmds_accepted != cmds_queued || byte_stream_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Write capacity only while the block is idle
    task automatic set_capacity(logic [15:0] cap);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = cap;
        model_cap = cap;
        cap_settings++;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial begin
        int unsigned ph;
        int unsigned n;
        logic [15:0] cap;

        model_pos = 16'd0;
        model_cap = CAP_RESET;

        // Hold reset, then release it on a falling edge
        aresetn = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 65;

        // Reset capacity: every command, pad ahead of each size, extreme values
        queue_cmd(OP_BYTE,     64'h0000_0000_0000_00FF);
        queue_cmd(OP_HALF,     64'h1234_5678_9ABC_A5C3);
        queue_cmd(OP_HEADER,   64'h0);
        queue_cmd(OP_BYTE,     64'hFFFF_FFFF_FFFF_FF00);
        queue_cmd(OP_WORD,     {64{1'b1}});
        queue_cmd(OP_BYTE,     64'h0000_0000_0000_005A);
        queue_cmd(OP_DOUBLE,   64'h0123_4567_89AB_CDEF);
        queue_cmd(OP_DOUBLE,   {64{1'b1}});
        queue_cmd(OP_SPARE_LO, {64{1'b1}});
        queue_cmd(OP_SPARE_HI, 64'h0);
        queue_cmd(OP_RESTART,  {64{1'b1}});

        // Zero capacity: every write fails, restart still succeeds
        set_capacity(16'd0);
        queue_cmd(OP_HEADER,  64'h0);
        queue_cmd(OP_BYTE,    64'h0000_0000_0000_0081);
        queue_cmd(OP_DOUBLE,  {64{1'b1}});
        queue_cmd(OP_RESTART, 64'h0);

        // Tight buffer: pad that stands before a failed value, pad cut at capacity
        set_capacity(16'd11);
        queue_cmd(OP_BYTE,   64'h0000_0000_0000_0081);
        queue_cmd(OP_DOUBLE, 64'hDEAD_BEEF_CAFE_F00D);
        queue_cmd(OP_HALF,   64'h0000_0000_0000_7E3C);
        queue_cmd(OP_WORD,   64'h0000_0000_1357_9BDF);
        queue_cmd(OP_BYTE,   64'h0000_0000_0000_0042);

        // Capacity below the position: no pad, every write fails until restart
        set_capacity(16'd5);
        queue_cmd(OP_HALF,    64'h0000_0000_0000_FFFF);
        queue_cmd(OP_HEADER,  64'h0);
        queue_cmd(OP_RESTART, 64'h0);
        queue_cmd(OP_HEADER,  64'h0);
        queue_cmd(OP_BYTE,    64'h0000_0000_0000_0099);

        // Random part: six phases, capacity changed between each,
        // idling swapped every two phases and dropped for the last two
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: cap = 16'hFFFF;
                1: cap = 16'($urandom_range(64, 8));
                2: cap = 16'd24;
                3: cap = 16'($urandom_range(40, 0));
                4: cap = CAP_RESET;
                default: cap = 16'($urandom_range(96, 1));
            endcase
            set_capacity(cap);
            if (ph < 2) begin
                send_idle_pct = 11;
                recv_idle_pct = 65;
            end else if (ph < 4) begin
                send_idle_pct = 65;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (n = 0; n < 31; n++) begin
                queue_random_cmd();
            end
        end

        wait_drained();

        $display("Covered %0d commands over %0d capacity settings (0 to 65535)",
                 cmds_accepted, cap_settings);
        $display("Checked %0d results: %0d buffer bytes, %0d failure closes, %0d errors",
                 results_seen, bytes_seen, fail_status, error_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
